[rtl/core/nchg_pkg.sv]
// Package for the NiMH charge phase controller: widths, constants, phase and
// register codes, the structs passed between stages, and the current clamp.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nchg_pkg;

  localparam int unsigned CodeW    = 12;
  localparam int unsigned ElapsedW = 17;
  localparam int unsigned CapW     = 14;
  localparam int unsigned OffsetW  = 11;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned WordW    = 16;
  localparam int unsigned MaW      = 9;
  localparam int unsigned RemW     = 17;
  localparam int unsigned VfixW    = 27;
  localparam int unsigned SlopeW   = 5;

  localparam logic [CapW-1:0]            CapReset      = 14'd1700;
  localparam logic signed [OffsetW-1:0]  OffsetReset   = 11'sd30;
  localparam logic [ElapsedW-1:0]        RapidLimReset = 17'd9000;
  localparam logic [ElapsedW-1:0]        TotalLimReset = 17'd36000;

  // thresholds in mV * 4096
  localparam logic signed [VfixW-1:0] VLowFix   = 27'sd5734400;
  localparam logic signed [VfixW-1:0] VHighFix  = 27'sd6553600;
  localparam logic [24:0]             CodeScale = 25'd5100;

  localparam logic [MaW-1:0] MaMax     = 9'd400;
  // x/5 == (x*52429) >> 18 for x < 2^18
  localparam logic [15:0]    Div5Mul   = 16'd52429;
  // DAC code = 8*mA + (mA*194 + 24817)/10000
  localparam logic [7:0]     MaScale   = 8'd194;
  localparam logic [RemW-1:0] RemBias  = 17'd24817;
  // r/10000 == (r*214749) >> 31 for r < 2^17
  localparam logic [17:0]    Div10kMul = 18'd214749;
  localparam logic [WordW-1:0] DacBase = 16'h7000;

  localparam logic signed [SlopeW-1:0] SlopeMax = 5'sd8;
  localparam logic signed [SlopeW-1:0] SlopeMin = -5'sd8;

  typedef enum logic [1:0] {
    PH_PRE   = 2'd0,
    PH_RAPID = 2'd1,
    PH_PERM  = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CAPACITY  = 8'd0,
    CFG_OFFSET    = 8'd1,
    CFG_RAPID_LIM = 8'd2,
    CFG_TOTAL_LIM = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [OffsetW-1:0] offset_mv;
    logic [ElapsedW-1:0]       rapid_limit_s;
    logic [ElapsedW-1:0]       total_limit_s;
    logic [MaW-1:0]            ma_pre;
    logic [MaW-1:0]            ma_rapid;
    logic [MaW-1:0]            ma_perm;
  } cfg_t;

  typedef struct packed {
    logic           dac_write;
    phase_e         phase;
    logic           peak_seen;
    logic           done_res;
    logic [MaW-1:0] ma;
    logic [RemW-1:0] rem;
  } stage_t;

  typedef struct packed {
    logic             dac_write;
    logic [WordW-1:0] dac_word;
    phase_e           phase;
    logic             peak_seen;
    logic             done_res;
  } res_t;

  function automatic logic [MaW-1:0] clamp_ma(input logic [12:0] val);
    logic [MaW-1:0] res;
    if (val > 13'(MaMax)) begin
      res = MaMax;
    end else begin
      res = val[MaW-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/core/nchg_if.sv]
// Channel interfaces of the charge phase controller: sample in, result out,
// configuration write. Depends on nchg_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface nchg_in_if import nchg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CodeW-1:0]    adc_code;
  logic [ElapsedW-1:0] elapsed_s;

  modport source (output valid, adc_code, elapsed_s, input ready);
  modport sink   (input valid, adc_code, elapsed_s, output ready);
endinterface

interface nchg_out_if import nchg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             dac_write;
  logic [WordW-1:0] dac_word;
  logic [1:0]       phase;
  logic             peak_seen;
  logic             done_res;

  modport source (output valid, dac_write, dac_word, phase, peak_seen, done_res,
                  input ready);
  modport sink   (input valid, dac_write, dac_word, phase, peak_seen, done_res,
                  output ready);
endinterface

interface nchg_cfg_if import nchg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/nimh_charge_phase_controller.sv]
// NiMH charge phase controller with delta-peak end of rapid charge.
// Pipeline: input register, phase/state stage, DAC word stage. Throughput:
// one request per cycle while the result sink takes results; result_o.ready
// low holds back the full stages.
// Reset: all phase flags, slope count and previous code clear; config
// registers return to 1700 mAh, 30 mV, 9000 s, 36000 s.
// Depends on nchg_pkg, nchg_if, nchg_cfg, nchg_phase, nchg_dac.
`timescale 1ns / 1ps
`default_nettype none

module nimh_charge_phase_controller import nchg_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  nchg_in_if.sink     sample_i,
  nchg_cfg_if.sink    cfg_i,
  nchg_out_if.source  result_o
);

  logic                in_valid_q;
  logic [CodeW-1:0]    code_q;
  logic [ElapsedW-1:0] elapsed_q;
  logic                adv_in, adv_phase, adv_out;
  logic                stage_valid, res_valid;
  cfg_t                cfg;
  stage_t              stage;
  res_t                res;

  assign adv_out   = !res_valid || result_o.ready;
  assign adv_phase = !stage_valid || adv_out;
  assign adv_in    = !in_valid_q || adv_phase;
  assign sample_i.ready = adv_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv_in) begin
      in_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && sample_i.valid) begin
      code_q    <= sample_i.adc_code;
      elapsed_q <= sample_i.elapsed_s;
    end
  end

  nchg_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  nchg_phase u_phase (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_q),
    .code_i    (code_q),
    .elapsed_i (elapsed_q),
    .cfg_i     (cfg),
    .adv_i     (adv_phase),
    .valid_o   (stage_valid),
    .stage_o   (stage)
  );

  nchg_dac u_dac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_valid),
    .stage_i (stage),
    .adv_i   (adv_out),
    .valid_o (res_valid),
    .res_o   (res)
  );

  assign result_o.valid     = res_valid;
  assign result_o.dac_write = res.dac_write;
  assign result_o.dac_word  = res.dac_word;
  assign result_o.phase     = res.phase;
  assign result_o.peak_seen = res.peak_seen;
  assign result_o.done_res  = res.done_res;

  a_word_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.dac_write |-> result_o.dac_word[15:12] == DacBase[15:12])
    else $error("DAC word without command nibble");

  a_word_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.dac_write |-> result_o.dac_word == '0)
    else $error("DAC word set without a write");

  a_done_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.done_res |-> result_o.phase == PH_DONE)
    else $error("complete flag outside complete phase");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid && !adv_phase |=> stage_valid && $stable(stage))
    else $error("stage result lost under stall");

endmodule

`default_nettype wire

[rtl/core/nchg_cfg.sv]
// Configuration registers and the per-phase current values derived from
// the capacity register. Depends on nchg_pkg and nchg_if.
`timescale 1ns / 1ps
`default_nettype none

module nchg_cfg import nchg_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  nchg_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  logic [CapW-1:0]           capacity_q;
  logic signed [OffsetW-1:0] offset_q;
  logic [ElapsedW-1:0]       rapid_lim_q;
  logic [ElapsedW-1:0]       total_lim_q;
  logic [MaW-1:0]            ma_pre_q, ma_rapid_q, ma_perm_q;
  logic [28:0]               tenth_prod, twentieth_prod;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= CapReset;
      offset_q    <= OffsetReset;
      rapid_lim_q <= RapidLimReset;
      total_lim_q <= TotalLimReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_CAPACITY:  capacity_q  <= cfg_i.data[CapW-1:0];
        CFG_OFFSET:    offset_q    <= $signed(cfg_i.data[OffsetW-1:0]);
        CFG_RAPID_LIM: rapid_lim_q <= cfg_i.data[ElapsedW-1:0];
        CFG_TOTAL_LIM: total_lim_q <= cfg_i.data[ElapsedW-1:0];
        default: ;
      endcase
    end
  end

  // capacity/10 = (capacity/2)/5, capacity/20 = (capacity/4)/5
  assign tenth_prod     = 29'(capacity_q[CapW-1:1]) * 29'(Div5Mul);
  assign twentieth_prod = 29'(capacity_q[CapW-1:2]) * 29'(Div5Mul);

  always_ff @(posedge clk_i) begin
    ma_pre_q   <= clamp_ma(13'(tenth_prod[28:18]));
    ma_rapid_q <= clamp_ma(capacity_q[CapW-1:1]);
    ma_perm_q  <= clamp_ma(13'(twentieth_prod[28:18]));
  end

  always_comb begin
    cfg_o.offset_mv     = offset_q;
    cfg_o.rapid_limit_s = rapid_lim_q;
    cfg_o.total_limit_s = total_lim_q;
    cfg_o.ma_pre        = ma_pre_q;
    cfg_o.ma_rapid      = ma_rapid_q;
    cfg_o.ma_perm       = ma_perm_q;
  end

endmodule

`default_nettype wire

[rtl/core/nchg_phase.sv]
// Phase selection, start flags, delta-peak slope counter and sticky
// completion; registers the per-request stage result. Depends on nchg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nchg_phase import nchg_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  input  wire [CodeW-1:0]     code_i,
  input  wire [ElapsedW-1:0]  elapsed_i,
  input  cfg_t                cfg_i,
  input  wire                 adv_i,
  output logic                valid_o,
  output stage_t              stage_o
);

  logic pre_q, pre_d, rapid_q, rapid_d, perm_q, perm_d;
  logic peak_q, peak_d, done_q, done_d;
  logic [CodeW-1:0]         prev_q, prev_d;
  logic signed [SlopeW-1:0] slope_q, slope_d;
  logic [24:0]              code_mv;
  logic signed [VfixW-1:0]  vfix;
  logic [16:0]              ma_term;
  logic                     valid_q;
  stage_t                   st, stage_q;

  assign code_mv = 25'(code_i) * CodeScale;
  assign vfix    = $signed({2'b00, code_mv}) +
                   $signed({{4{cfg_i.offset_mv[OffsetW-1]}}, cfg_i.offset_mv, 12'b0});

  always_comb begin
    pre_d   = pre_q;
    rapid_d = rapid_q;
    perm_d  = perm_q;
    peak_d  = peak_q;
    done_d  = done_q;
    prev_d  = prev_q;
    slope_d = slope_q;
    st      = '0;
    st.phase = PH_DONE;
    priority if (done_q) begin
      st.phase = PH_DONE;
    end else if (vfix <= VLowFix) begin
      st.phase = PH_PRE;
      if (!pre_q) begin
        pre_d        = 1'b1;
        st.dac_write = 1'b1;
        st.ma        = cfg_i.ma_pre;
      end
    end else if (vfix <= VHighFix && elapsed_i < cfg_i.rapid_limit_s && !peak_q) begin
      st.phase = PH_RAPID;
      if (!rapid_q) begin
        rapid_d      = 1'b1;
        st.dac_write = 1'b1;
        st.ma        = cfg_i.ma_rapid;
      end
      priority if (code_i > prev_q) begin
        if (slope_q != SlopeMax) begin
          slope_d = slope_q + 5'sd1;
        end
        prev_d = code_i;
      end else if (code_i < prev_q) begin
        slope_d = slope_q - 5'sd1;
        if (slope_q == SlopeMin) begin
          peak_d = 1'b1;
        end else begin
          prev_d = code_i;
        end
      end else begin
        prev_d = code_i;
      end
    end else if (elapsed_i < cfg_i.total_limit_s) begin
      st.phase = PH_PERM;
      if (!perm_q) begin
        perm_d       = 1'b1;
        st.dac_write = 1'b1;
        st.ma        = cfg_i.ma_perm;
      end
    end else begin
      st.phase     = PH_DONE;
      done_d       = 1'b1;
      st.dac_write = 1'b1;
    end
    st.peak_seen = peak_d;
    st.done_res  = done_d;
    ma_term      = 17'(st.ma) * 17'(MaScale);
    st.rem       = ma_term + RemBias;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q   <= 1'b0;
      rapid_q <= 1'b0;
      perm_q  <= 1'b0;
      peak_q  <= 1'b0;
      done_q  <= 1'b0;
      prev_q  <= '0;
      slope_q <= '0;
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
      if (valid_i) begin
        pre_q   <= pre_d;
        rapid_q <= rapid_d;
        perm_q  <= perm_d;
        peak_q  <= peak_d;
        done_q  <= done_d;
        prev_q  <= prev_d;
        slope_q <= slope_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      stage_q <= st;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

[rtl/core/nchg_dac.sv]
// DAC word assembly and the result register.
// Depends on nchg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nchg_dac import nchg_pkg::*; (
  input  wire     clk_i,
  input  wire     rst_ni,
  input  wire     valid_i,
  input  stage_t  stage_i,
  input  wire     adv_i,
  output logic    valid_o,
  output res_t    res_o
);

  logic [34:0]      quot_prod;
  logic [3:0]       quot;
  logic [WordW-1:0] word;
  logic             valid_q;
  res_t             res_d, res_q;

  assign quot_prod = 35'(stage_i.rem) * 35'(Div10kMul);
  assign quot      = quot_prod[34:31];

  always_comb begin
    if (!stage_i.dac_write) begin
      word = '0;
    end else if (stage_i.phase == PH_DONE) begin
      word = DacBase;
    end else begin
      word = DacBase + 16'({stage_i.ma, 3'b000}) + 16'(quot);
    end
    res_d.dac_write = stage_i.dac_write;
    res_d.dac_word  = word;
    res_d.phase     = stage_i.phase;
    res_d.peak_seen = stage_i.peak_seen;
    res_d.done_res  = stage_i.done_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

[bench/nimh_charge_phase_controller_test.sv]
// Self-checking bench for the NiMH charge phase controller: drives sample and
// register requests, predicts every result and compares it as one packed value.
// Depends on nchg_pkg, nchg_if and the controller RTL.
`timescale 1ns / 1ps

module nimh_charge_phase_controller_test;
  import nchg_pkg::*;

  localparam int QuietLimit = 3000;

  typedef struct packed {
    logic [CodeW-1:0]    code;
    logic [ElapsedW-1:0] secs;
  } sample_t;

  logic clk_i;
  logic rst_ni;

  nchg_in_if  sample_ch ();
  nchg_out_if result_ch ();
  nchg_cfg_if cfg_ch ();

  nimh_charge_phase_controller i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_ch),
    .cfg_i   (cfg_ch),
    .result_o(result_ch)
  );

  // charger copy: registers and phase state
  logic [CapW-1:0]     cap_mah   = CapReset;
  int                  offs_mv   = 30;
  logic [ElapsedW-1:0] rapid_lim = RapidLimReset;
  logic [ElapsedW-1:0] total_lim = TotalLimReset;
  bit                  pre_on, rapid_on, perm_on, peak_hit, done_hit;
  logic [CodeW-1:0]    last_code = '0;
  int                  slope     = 0;

  sample_t sample_q[$];
  res_t    phase_report_q[$];
  sample_t next_sample;
  res_t    got, want;
  bit      sample_took;
  int      src_idle_pct   = 0;
  int      sink_stall_pct = 0;
  int      stall_hold     = 0;
  int      mismatch_cnt   = 0;
  int      quiet_cycles   = 0;
  int      walk_code      = 0;

  function automatic logic [WordW-1:0] phase_dac(int unsigned divisor);
    int unsigned ma;
    ma = cap_mah / divisor;
    if (ma > MaMax) begin
      ma = MaMax;
    end
    return DacBase + WordW'((ma * 80194 + 24817) / 10000);
  endfunction

  function automatic res_t charge_step(logic [CodeW-1:0] code, logic [ElapsedW-1:0] secs);
    res_t   r;
    longint vfix;
    r = '0;
    if (done_hit) begin
      r.phase = PH_DONE;
    end else begin
      vfix = longint'(code) * 5100 + longint'(offs_mv) * 4096;
      if (vfix <= longint'(VLowFix)) begin
        r.phase = PH_PRE;
        if (!pre_on) begin
          pre_on      = 1'b1;
          r.dac_write = 1'b1;
          r.dac_word  = phase_dac(10);
        end
      end else if (vfix <= longint'(VHighFix) && secs < rapid_lim && !peak_hit) begin
        r.phase = PH_RAPID;
        if (!rapid_on) begin
          rapid_on    = 1'b1;
          r.dac_write = 1'b1;
          r.dac_word  = phase_dac(2);
        end
        if (code > last_code) begin
          if (slope < int'(SlopeMax)) slope++;
          last_code = code;
        end else if (code < last_code) begin
          slope--;
          // delta peak: previous code is kept on the firing sample
          if (slope < int'(SlopeMin)) peak_hit = 1'b1;
          else last_code = code;
        end
      end else if (secs < total_lim) begin
        r.phase = PH_PERM;
        if (!perm_on) begin
          perm_on     = 1'b1;
          r.dac_write = 1'b1;
          r.dac_word  = phase_dac(20);
        end
      end else begin
        r.phase     = PH_DONE;
        done_hit    = 1'b1;
        r.dac_write = 1'b1;
        r.dac_word  = DacBase;
      end
    end
    r.peak_seen = peak_hit;
    r.done_res  = done_hit;
    return r;
  endfunction

  function automatic void rapid_window(output int lo, output int hi);
    longint v;
    lo = -1;
    hi = -1;
    for (int c = 0; c < 4096; c++) begin
      v = longint'(c) * 5100 + longint'(offs_mv) * 4096;
      if (v > longint'(VLowFix) && v <= longint'(VHighFix)) begin
        if (lo < 0) lo = c;
        hi = c;
      end
    end
  endfunction

  function automatic string res_text(res_t r);
    return $sformatf("write=%0b word=%h phase=%0d peak=%0b done=%0b",
                     r.dac_write, r.dac_word, r.phase, r.peak_seen, r.done_res);
  endfunction

  task automatic push_sample(int code, int secs);
    sample_t s;
    s.code = code[CodeW-1:0];
    s.secs = secs[ElapsedW-1:0];
    sample_q.push_back(s);
  endtask

  // rising charge curve inside the rapid band, with some noise and limit hits
  task automatic push_charge(int n);
    int lo, hi, roll, stride, secs;
    rapid_window(lo, hi);
    if (walk_code < lo || walk_code > hi) walk_code = (lo + hi) / 2;
    repeat (n) begin
      roll   = $urandom_range(99);
      stride = $urandom_range(3, 1);
      if (rapid_lim > 0) secs = $urandom_range(int'(rapid_lim) - 1);
      else secs = $urandom_range(131070);
      if (roll < 6) begin
        push_sample($urandom_range(4095), $urandom_range(131070));
      end else if (roll < 10 && rapid_lim <= 131070) begin
        push_sample(walk_code, $urandom_range(131070, int'(rapid_lim)));
      end else if (roll < 13 && rapid_lim <= 131070 && rapid_lim > 0) begin
        push_sample(walk_code, int'(rapid_lim) - int'($urandom_range(1)));
      end else begin
        roll = $urandom_range(99);
        if (roll < 65) walk_code = (walk_code + stride > hi) ? hi : walk_code + stride;
        else if (roll < 85) walk_code = (walk_code - stride < lo) ? lo : walk_code - stride;
        push_sample(walk_code, secs);
      end
    end
  endtask

  task automatic push_mixed(int n, bit all_secs);
    int lo, hi;
    rapid_window(lo, hi);
    repeat (n) begin
      push_sample(($urandom_range(1) != 0) ? $urandom_range(4095) : $urandom_range(hi + 8, lo - 8),
                  all_secs ? $urandom_range(131071) : $urandom_range(131070));
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      CFG_CAPACITY:  cap_mah   = val[CapW-1:0];
      CFG_OFFSET:    offs_mv   = $signed(val[OffsetW-1:0]);
      CFG_RAPID_LIM: rapid_lim = val[ElapsedW-1:0];
      CFG_TOTAL_LIM: total_lim = val[ElapsedW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (sample_q.size() != 0 || sample_ch.valid || phase_report_q.size() != 0);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // request driver
  always @(negedge clk_i) begin
    if (!sample_ch.valid || sample_took) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        next_sample = sample_q.pop_front();
        sample_ch.valid     <= 1'b1;
        sample_ch.adc_code  <= next_sample.code;
        sample_ch.elapsed_s <= next_sample.secs;
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    sample_took = rst_ni && sample_ch.valid && sample_ch.ready;
    if (sample_took) begin
      phase_report_q.push_back(charge_step(sample_ch.adc_code, sample_ch.elapsed_s));
    end
  end

  // result monitor
  always @(negedge clk_i) begin
    if (stall_hold > 0) begin
      result_ch.ready <= 1'b0;
      stall_hold--;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      got.dac_write = result_ch.dac_write;
      got.dac_word  = result_ch.dac_word;
      got.phase     = phase_e'(result_ch.phase);
      got.peak_seen = result_ch.peak_seen;
      got.done_res  = result_ch.done_res;
      if (phase_report_q.size() == 0) begin
        $display("%0t: unexpected result, actual %s", $time, res_text(got));
        mismatch_cnt++;
      end else begin
        want = phase_report_q.pop_front();
        if (got !== want) begin
          $display("%0t: result mismatch, expected %s, actual %s",
                   $time, res_text(want), res_text(got));
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int lo, hi, c;
    rst_ni              = 1'b0;
    sample_ch.valid     = 1'b0;
    sample_ch.adc_code  = '0;
    sample_ch.elapsed_s = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CFG_CAPACITY;
    cfg_ch.data         = '0;
    result_ch.ready     = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: thresholds, first entries, re-entry, slope saturation
    write_reg(CFG_CAPACITY, 17'h1FFFF);
    write_reg(CFG_OFFSET, 17'(-1000));
    write_reg(CFG_RAPID_LIM, 17'd131071);
    write_reg(CFG_TOTAL_LIM, 17'd131071);
    rapid_window(lo, hi);
    push_sample(0, 0);
    push_sample(lo - 1, 5);
    push_sample(4095, 131070);
    push_sample(hi + 1, 7);
    wait_drained();
    write_reg(CFG_CAPACITY, 17'd0);
    push_sample(lo, 0);
    push_sample(hi, 131070);
    push_sample(hi, 1);
    push_sample(lo, 2);
    for (c = 1; c <= 9; c++) push_sample(lo + c, c);
    push_sample(4095, 131070);
    push_sample(0, 131071);
    wait_drained();

    write_reg(CFG_CAPACITY, 17'd1700);
    write_reg(CFG_OFFSET, 17'd30);
    write_reg(CFG_RAPID_LIM, 17'd9000);
    push_charge(250);
    wait_drained();
    stall_hold = 150;
    push_charge(200);
    wait_drained();

    src_idle_pct = 83;
    write_reg(CFG_OFFSET, 17'd1000);
    write_reg(CFG_RAPID_LIM, 17'd131071);
    write_reg(CFG_CAPACITY, 17'd10000);
    push_charge(450);
    wait_drained();

    src_idle_pct   = 0;
    sink_stall_pct = 83;
    write_reg(CFG_OFFSET, 17'd0);
    write_reg(CFG_RAPID_LIM, 17'd0);
    push_charge(100);
    wait_drained();
    write_reg(CFG_RAPID_LIM, 17'd9000);
    push_charge(350);
    wait_drained();

    src_idle_pct   = 18;
    sink_stall_pct = 18;
    write_reg(CFG_OFFSET, 17'(-1000));
    write_reg(CFG_RAPID_LIM, 17'd131071);
    push_charge(300);
    // falling voltage run ends rapid charge
    rapid_window(lo, hi);
    c = hi;
    repeat (20) begin
      push_sample(c, $urandom_range(131070));
      c -= $urandom_range(3, 1);
    end
    push_mixed(250, 1'b0);
    wait_drained();

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    write_reg(CFG_TOTAL_LIM, 17'd50000);
    push_sample(4095, 49999);
    push_sample(0, 131071);
    push_sample(4095, 50000);
    wait_drained();
    write_reg(CFG_TOTAL_LIM, 17'd0);
    src_idle_pct   = 18;
    sink_stall_pct = 18;
    push_mixed(40, 1'b1);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && phase_report_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
